[src/bsgt_pkg.sv]
// ----------------------------------------------------------------------------
// bsgt_pkg: shared types and constants of the bright spot gesture tracker
// Pixel and result beat layouts, register indexes, reset values and sizes.
// ----------------------------------------------------------------------------
package bsgt_pkg;

  localparam int SAMPLE_W  = 8;
  localparam int POS_W     = 11;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 12;
  localparam int LANES     = 3;

  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_HEIGHT = 2048;

  localparam logic [7:0]  RST_INTENSITY = 8'd230;
  localparam logic [1:0]  RST_CHANNELS  = 2'd3;
  localparam logic [11:0] RST_WIDTH     = 12'd640;
  localparam logic [11:0] RST_HEIGHT    = 12'd480;
  localparam logic [10:0] RST_MOVEMENT  = 11'd20;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INTENSITY = 3'd0,
    CFG_CHANNELS  = 3'd1,
    CFG_WIDTH     = 3'd2,
    CFG_HEIGHT    = 3'd3,
    CFG_MOVEMENT  = 3'd4
  } cfg_index_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_a;
    logic [SAMPLE_W-1:0] sample_b;
    logic [SAMPLE_W-1:0] sample_c;
  } pixel_t;

  typedef struct packed {
    logic             spot_found;
    logic [POS_W-1:0] spot_x;
    logic [POS_W-1:0] spot_y;
    logic             gesture_done;
    logic [POS_W-1:0] start_x;
    logic [POS_W-1:0] start_y;
    logic             no_movement;
    logic             move_left;
    logic             move_right;
    logic             move_up;
    logic             move_down;
  } result_t;

  typedef struct packed {
    logic done;
    logic no_movement;
    logic left;
    logic right;
    logic up;
    logic down;
  } gesture_flags_t;

endpackage

[src/bsgt_lane.sv]
// ----------------------------------------------------------------------------
// bsgt_lane: threshold comparator for one colour channel
// Flags the channel when it is enabled and strictly above the threshold.
// ----------------------------------------------------------------------------
module bsgt_lane
  import bsgt_pkg::*;
(
  input  logic [SAMPLE_W-1:0] sample,
  input  logic [SAMPLE_W-1:0] threshold,
  input  logic                enable,
  output logic                hit
);

  assign hit = enable && (sample > threshold);

endmodule

[src/bsgt_gesture.sv]
// ----------------------------------------------------------------------------
// bsgt_gesture: end-of-frame gesture classifier
// Compares the last spot position with the gesture start point.
// ----------------------------------------------------------------------------
module bsgt_gesture
  import bsgt_pkg::*;
#(
  parameter int XW = 11,
  parameter int YW = 11
) (
  input  logic [XW-1:0]    last_x,
  input  logic [YW-1:0]    last_y,
  input  logic [XW-1:0]    start_x,
  input  logic [YW-1:0]    start_y,
  input  logic [POS_W-1:0] threshold,
  input  logic             found,
  input  logic             tracking,
  output gesture_flags_t   flags
);

  localparam int GXW = (XW > POS_W) ? XW : POS_W;
  localparam int GYW = (YW > POS_W) ? YW : POS_W;

  logic [XW-1:0] mx;
  logic [YW-1:0] my;
  logic          x_pos;
  logic          y_pos;
  logic          x_over;
  logic          y_over;
  logic          x_under;
  logic          y_under;
  logic          done;

  assign x_pos   = last_x > start_x;
  assign y_pos   = last_y > start_y;
  assign mx      = x_pos ? (last_x - start_x) : (start_x - last_x);
  assign my      = y_pos ? (last_y - start_y) : (start_y - last_y);
  assign x_over  = GXW'(mx) > GXW'(threshold);
  assign y_over  = GYW'(my) > GYW'(threshold);
  assign x_under = GXW'(mx) < GXW'(threshold);
  assign y_under = GYW'(my) < GYW'(threshold);
  assign done    = !found && tracking;

  always_comb begin
    flags.done        = done;
    flags.no_movement = done && x_under && y_under;
    flags.right       = done && x_over && x_pos;
    flags.left        = done && x_over && !x_pos;
    flags.down        = done && y_over && y_pos;
    flags.up          = done && y_over && !y_pos;
  end

endmodule

[src/bright_spot_gesture_tracker.sv]
// ----------------------------------------------------------------------------
// bright_spot_gesture_tracker: bright spot locator and swipe classifier
// Finds the last bright pixel of each frame and reports gestures.
// ----------------------------------------------------------------------------
// Usage: pixels enter on the pix channel in raster order, one beat per pixel,
// carrying up to three channel bytes. Three comparator lanes test the
// channels side by side and their hits are merged into one spot decision.
// One result beat leaves on the res channel for the last pixel of each
// frame; every other pixel produces nothing. The result is registered, so it
// appears in the cycle after the final pixel of the frame is accepted.
// Throughput is one pixel per cycle, set by the single registered stage that
// holds the position counters and gesture state. While a result waits on a
// stalled receiver, pixels that do not end a frame are still taken; only the
// frame's final pixel waits for the result register to empty.
// Registers are written on the cfg channel, which is always ready, and
// should be written only while no frame is in progress.
// Reset (rst, synchronous) restores default registers (threshold 230, three
// channels, 640 by 480, movement threshold 20), zeroes the counters and
// positions, and drops any pending result.
// ----------------------------------------------------------------------------
module bright_spot_gesture_tracker
  import bsgt_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  pix_valid,
  output logic                  pix_ready,
  input  pixel_t                pix,
  output logic                  res_valid,
  input  logic                  res_ready,
  output result_t               res,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Counter widths follow the largest frame size; the size arithmetic needs
  // one more bit so that the maximum itself can be represented.
  localparam int XW  = $clog2(MAX_WIDTH);
  localparam int YW  = $clog2(MAX_HEIGHT);
  localparam int SXW = (XW + 1 > CFG_DATA_W) ? XW + 1 : CFG_DATA_W;
  localparam int SYW = (YW + 1 > CFG_DATA_W) ? YW + 1 : CFG_DATA_W;

  // Configuration registers.
  logic [SAMPLE_W-1:0]   intensity_threshold;
  logic [1:0]            channel_count;
  logic [CFG_DATA_W-1:0] frame_width;
  logic [CFG_DATA_W-1:0] frame_height;
  logic [POS_W-1:0]      movement_threshold;

  // Tracking state.
  logic [XW-1:0] column_count;
  logic [YW-1:0] row_count;
  logic          found_in_frame;
  logic [XW-1:0] last_spot_x;
  logic [YW-1:0] last_spot_y;
  logic          tracking;
  logic [XW-1:0] gesture_start_x;
  logic [YW-1:0] gesture_start_y;

  logic [SXW-1:0]      width_eff;
  logic [SYW-1:0]      height_eff;
  logic                row_end;
  logic                frame_end;
  logic                pix_beat;
  logic [SAMPLE_W-1:0] lane_sample [LANES];
  logic [LANES-1:0]    lane_enable;
  logic [LANES-1:0]    lane_hit;
  logic                spot;
  logic                found_now;
  logic [XW-1:0]       last_spot_x_next;
  logic [YW-1:0]       last_spot_y_next;
  logic [XW-1:0]       start_x_next;
  logic [YW-1:0]       start_y_next;
  gesture_flags_t      flags;

  // The configuration port never stalls.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      intensity_threshold <= RST_INTENSITY;
      channel_count       <= RST_CHANNELS;
      frame_width         <= RST_WIDTH;
      frame_height        <= RST_HEIGHT;
      movement_threshold  <= RST_MOVEMENT;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_INTENSITY: intensity_threshold <= cfg_data[SAMPLE_W-1:0];
        CFG_CHANNELS:  channel_count       <= cfg_data[1:0];
        CFG_WIDTH:     frame_width         <= cfg_data;
        CFG_HEIGHT:    frame_height        <= cfg_data;
        CFG_MOVEMENT:  movement_threshold  <= cfg_data[POS_W-1:0];
        default: ;
      endcase
    end
  end

  // A zero size counts as one, and an oversized one is held at the maximum.
  always_comb begin
    if (frame_width == '0) begin
      width_eff = SXW'(1);
    end else if (SXW'(frame_width) > SXW'(MAX_WIDTH)) begin
      width_eff = SXW'(MAX_WIDTH);
    end else begin
      width_eff = SXW'(frame_width);
    end
    if (frame_height == '0) begin
      height_eff = SYW'(1);
    end else if (SYW'(frame_height) > SYW'(MAX_HEIGHT)) begin
      height_eff = SYW'(MAX_HEIGHT);
    end else begin
      height_eff = SYW'(frame_height);
    end
  end

  // "At least" rather than "equal" so that a counter left beyond a shrunken
  // size still wraps on the next pixel.
  assign row_end   = (SXW'(column_count) + SXW'(1)) >= width_eff;
  assign frame_end = row_end && ((SYW'(row_count) + SYW'(1)) >= height_eff);

  // Only the pixel that closes a frame needs room in the result register.
  assign pix_ready = !frame_end || !res_valid || res_ready;
  assign pix_beat  = pix_valid && pix_ready;

  // Comparator lanes, one per colour channel, then the merge.
  assign lane_sample[0] = pix.sample_a;
  assign lane_sample[1] = pix.sample_b;
  assign lane_sample[2] = pix.sample_c;
  assign lane_enable[0] = 1'b1;
  assign lane_enable[1] = channel_count >= 2'd2;
  assign lane_enable[2] = channel_count >= 2'd3;

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    bsgt_lane u_lane (
      .sample    (lane_sample[i]),
      .threshold (intensity_threshold),
      .enable    (lane_enable[i]),
      .hit       (lane_hit[i])
    );
  end

  assign spot             = |lane_hit;
  assign found_now        = found_in_frame || spot;
  assign last_spot_x_next = spot ? column_count : last_spot_x;
  assign last_spot_y_next = spot ? row_count : last_spot_y;

  // A gesture starts on the first frame with a spot.
  assign start_x_next = (found_now && !tracking) ? last_spot_x_next : gesture_start_x;
  assign start_y_next = (found_now && !tracking) ? last_spot_y_next : gesture_start_y;

  bsgt_gesture #(
    .XW (XW),
    .YW (YW)
  ) u_gesture (
    .last_x    (last_spot_x_next),
    .last_y    (last_spot_y_next),
    .start_x   (gesture_start_x),
    .start_y   (gesture_start_y),
    .threshold (movement_threshold),
    .found     (found_now),
    .tracking  (tracking),
    .flags     (flags)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count    <= '0;
      row_count       <= '0;
      found_in_frame  <= 1'b0;
      last_spot_x     <= '0;
      last_spot_y     <= '0;
      tracking        <= 1'b0;
      gesture_start_x <= '0;
      gesture_start_y <= '0;
    end else if (pix_beat) begin
      last_spot_x <= last_spot_x_next;
      last_spot_y <= last_spot_y_next;
      if (row_end) begin
        column_count <= '0;
        row_count    <= frame_end ? '0 : row_count + YW'(1);
      end else begin
        column_count <= column_count + XW'(1);
      end
      if (frame_end) begin
        found_in_frame  <= 1'b0;
        tracking        <= found_now;
        gesture_start_x <= start_x_next;
        gesture_start_y <= start_y_next;
      end else begin
        found_in_frame <= found_now;
      end
    end
  end

  // Result register: loaded by the pixel that closes a frame.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (pix_beat && frame_end) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_beat && frame_end) begin
      res.spot_found   <= found_now;
      res.spot_x       <= POS_W'(last_spot_x_next);
      res.spot_y       <= POS_W'(last_spot_y_next);
      res.gesture_done <= flags.done;
      res.start_x      <= POS_W'(start_x_next);
      res.start_y      <= POS_W'(start_y_next);
      res.no_movement  <= flags.no_movement;
      res.move_left    <= flags.left;
      res.move_right   <= flags.right;
      res.move_up      <= flags.up;
      res.move_down    <= flags.down;
    end
  end

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (pix_beat && frame_end) |-> (!res_valid || res_ready))
    else $error("result overwritten before it was taken");

  a_done_without_spot: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res.gesture_done && res.spot_found))
    else $error("gesture ended in a frame that had a spot");

  a_flags_need_done: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res.gesture_done) |-> !(res.no_movement || res.move_left ||
      res.move_right || res.move_up || res.move_down))
    else $error("direction flag without a finished gesture");

  a_opposite_flags: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res.move_left && res.move_right) && !(res.move_up && res.move_down))
    else $error("opposite directions flagged together");

  a_tracking_follows: assert property (@(posedge clk) disable iff (rst)
    (pix_beat && frame_end) |=> (tracking == res.spot_found))
    else $error("tracking state disagrees with the frame result");
`endif

endmodule
